@@ rtl/core/trapezoidal_velocity_profile_core_assert.svh @@
// ----------------------------------------------------------------------------
// Trapezoidal velocity profile core: assertion macros
// Concurrent assertion shorthands clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef TRAPEZOIDAL_VELOCITY_PROFILE_CORE_ASSERT_SVH
`define TRAPEZOIDAL_VELOCITY_PROFILE_CORE_ASSERT_SVH

// same-cycle implication
`define TVP_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define TVP_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/tvp_pkg.sv @@
// ----------------------------------------------------------------------------
// tvp_pkg
// Shared types and constants of the trapezoidal velocity profile core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tvp_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int WORD_BITS_DEF = 32;
  localparam int FIELD_BITS    = 31;
  localparam int ADDR_BITS     = 4;
  localparam int DATA_BITS     = 32;

  localparam logic [FIELD_BITS-1:0] REG_ONE_RESET = 31'd65536;
  localparam logic [FIELD_BITS-1:0] STEP_DIV      = 31'd200;

  // x/200 as ((x >> 3) * ceil(2^35/25)) >> 35, exact for x below 2^32
  localparam int                    AVG_PRE   = 3;
  localparam int                    AVG_SHIFT = 35;
  localparam logic [FIELD_BITS-1:0] AVG_RECIP = 31'd1374389535;

  localparam logic [1:0] REG_DISTANCE = 2'd0;
  localparam logic [1:0] REG_SPEED    = 2'd1;
  localparam logic [1:0] REG_ACCEL    = 2'd2;

  localparam logic [1:0] SEG_IDLE   = 2'd0;
  localparam logic [1:0] SEG_ACCEL  = 2'd1;
  localparam logic [1:0] SEG_CRUISE = 2'd2;
  localparam logic [1:0] SEG_DECEL  = 2'd3;

  typedef enum logic [1:0] {
    OP_MUL,
    OP_DIV,
    OP_SQRT
  } op_t;

  typedef struct packed {
    logic start;
    op_t  op;
  } unit_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_status_t;

endpackage

@@ rtl/core/tvp_iter_unit.sv @@
// ----------------------------------------------------------------------------
// tvp_iter_unit
// Shared iterative unit: shift-add multiply, restoring divide and
// digit-by-digit square root, one step per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tvp_iter_unit #(
  parameter int AW = 63
) (
  input  logic                               clk,
  input  logic                               rst,
  input  tvp_pkg::unit_ctrl_t                ctrl,
  input  logic [AW-1:0]                      opa,
  input  logic [tvp_pkg::FIELD_BITS-1:0]     opb,
  output tvp_pkg::unit_status_t              status,
  output logic [AW-1:0]                      result
);
  import tvp_pkg::*;

  localparam int CW       = $clog2(AW + 1);
  localparam int RW       = FIELD_BITS + 4;
  localparam int SQ_SHIFT = AW - 2 * FIELD_BITS;

  op_t                   op;
  logic                  busy;
  logic                  done;
  logic [CW-1:0]         cnt;
  logic [AW-1:0]         acc;
  logic [AW-1:0]         src;
  logic [FIELD_BITS-1:0] dvs;
  logic [RW-1:0]         rem;

  logic [AW-1:0]           mul_next;
  logic [FIELD_BITS+1:0]   div_rs;
  logic [FIELD_BITS+1:0]   div_sub;
  logic                    div_ge;
  logic [RW-1:0]           sq_rs;
  logic [RW-1:0]           sq_trial;
  logic                    sq_ge;

  always_comb begin
    mul_next = (acc << 1) + (dvs[FIELD_BITS-1] ? src : '0);
    div_rs   = {rem[FIELD_BITS:0], src[AW-1]};
    div_sub  = {2'b00, dvs};
    div_ge   = (div_rs >= div_sub);
    sq_rs    = {rem[RW-3:0], src[AW-1 -: 2]};
    sq_trial = {2'b00, acc[FIELD_BITS-1:0], 2'b01};
    sq_ge    = (sq_rs >= sq_trial);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
      op   <= OP_DIV;
    end else begin
      done <= 1'b0;
      if (ctrl.start) begin
        busy <= 1'b1;
        op   <= ctrl.op;
        cnt  <= (ctrl.op == OP_DIV) ? CW'(AW) : CW'(FIELD_BITS);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.start) begin
      acc <= '0;
      rem <= '0;
      dvs <= opb;
      src <= (ctrl.op == OP_SQRT) ? (opa << SQ_SHIFT) : opa;
    end else if (busy) begin
      case (op)
        OP_MUL: begin
          acc <= mul_next;
          dvs <= dvs << 1;
        end
        OP_DIV: begin
          rem <= div_ge ? RW'(div_rs - div_sub) : RW'(div_rs);
          acc <= {acc[AW-2:0], div_ge};
          src <= src << 1;
        end
        OP_SQRT: begin
          rem <= sq_ge ? (sq_rs - sq_trial) : sq_rs;
          acc <= {acc[AW-2:0], sq_ge};
          src <= src << 2;
        end
        default: begin
          acc <= acc;
        end
      endcase
    end
  end

  assign status.busy = busy;
  assign status.done = done;
  assign result      = acc;

endmodule

@@ rtl/core/trapezoidal_velocity_profile_core.sv @@
// Timing: a triangular start adds the product, root and second ramp steps; any
//   transaction may wait for the previous response to be taken. AW = WORD_BITS+31,
//   min 62.
// Throughput: one transaction at a time; the shared iterative unit sets it.
// Reset: synchronous, active high; registers to reset values, profile cleared.
// ----------------------------------------------------------------------------
// trapezoidal_velocity_profile_core
// Trapezoidal/triangular motion reference with trapezoid-rule position.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module trapezoidal_velocity_profile_core #(
  parameter int FRAC_BITS = tvp_pkg::FRAC_BITS_DEF,
  parameter int WORD_BITS = tvp_pkg::WORD_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [tvp_pkg::ADDR_BITS-1:0]  paddr,
  input  logic [tvp_pkg::DATA_BITS-1:0]  pwdata,
  output logic [tvp_pkg::DATA_BITS-1:0]  prdata,
  output logic                           pready,
  input  logic                           req_valid,
  output logic                           req_ready,
  input  logic                           func,
  input  logic [tvp_pkg::FIELD_BITS-1:0] sample_time,
  output logic                           rsp_valid,
  input  logic                           rsp_ready,
  output logic [tvp_pkg::FIELD_BITS-1:0] velocity_ref,
  output logic [tvp_pkg::FIELD_BITS-1:0] position_ref,
  output logic [1:0]                     segment,
  output logic                           triangular
);
  import tvp_pkg::*;

  localparam int AW0      = WORD_BITS + FIELD_BITS;
  localparam int AW       = (AW0 > 2 * FIELD_BITS) ? AW0 : 2 * FIELD_BITS;
  localparam int XW       = (WORD_BITS > 32) ? WORD_BITS : 32;
  localparam int POS_BITS = (WORD_BITS < FIELD_BITS) ? WORD_BITS : FIELD_BITS;
  localparam logic [AW-1:0] POS_MAX = {{(AW-POS_BITS){1'b0}}, {POS_BITS{1'b1}}};

  typedef enum logic [3:0] {
    S_IDLE, S_DIST, S_RAMP, S_CMP, S_PROD, S_ROOT, S_RAMP2, S_ENDS,
    S_SEG, S_NORM, S_MUL, S_DIV, S_AVG, S_ACC, S_OUT
  } state_t;

  state_t state;

  logic [FIELD_BITS-1:0] target_distance;
  logic [FIELD_BITS-1:0] top_speed;
  logic [FIELD_BITS-1:0] acceleration;

  logic [WORD_BITS-1:0] accel_end_time;
  logic [WORD_BITS-1:0] cruise_end_time;
  logic [WORD_BITS-1:0] decel_end_time;
  logic [WORD_BITS-1:0] peak_speed;
  logic [WORD_BITS-1:0] position_accumulator;
  logic [WORD_BITS-1:0] previous_speed;
  logic                 triangle_flag;

  logic                  launched;
  logic [FIELD_BITS-1:0] t_r;
  logic [FIELD_BITS-1:0] d_r;
  logic [FIELD_BITS-1:0] v_r;
  logic [FIELD_BITS-1:0] a_r;
  logic [WORD_BITS-1:0]  t_dist;
  logic [WORD_BITS-1:0]  t_ramp;
  logic [AW-1:0]         work;
  logic [XW-1:0]         num;
  logic [XW-1:0]         den;
  logic [WORD_BITS-1:0]  speed;
  logic [1:0]            seg_r;

  unit_ctrl_t            u_ctrl;
  unit_status_t          u_status;
  logic [AW-1:0]         u_opa;
  logic [FIELD_BITS-1:0] u_opb;
  logic [AW-1:0]         u_result;
  logic                  op_state;

  logic [XW-1:0]        t_x;
  logic [XW-1:0]        ae_x;
  logic [XW-1:0]        ce_x;
  logic [XW-1:0]        de_x;
  logic [WORD_BITS-1:0] cend_val;
  logic [WORD_BITS:0]   dsum;
  logic [AW-1:0]        pos_sum;
  logic                 wr_en;

  function automatic logic [WORD_BITS-1:0] sat_word(input logic [AW-1:0] x);
    if (x[AW-1:WORD_BITS] != '0) begin
      sat_word = '1;
    end else begin
      sat_word = x[WORD_BITS-1:0];
    end
  endfunction

  // configuration port
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      target_distance <= '0;
      top_speed       <= REG_ONE_RESET;
      acceleration    <= REG_ONE_RESET;
    end else if (wr_en) begin
      case (paddr[3:2])
        REG_DISTANCE: target_distance <= pwdata[FIELD_BITS-1:0];
        REG_SPEED:    top_speed       <= pwdata[FIELD_BITS-1:0];
        REG_ACCEL:    acceleration    <= pwdata[FIELD_BITS-1:0];
        default:      target_distance <= target_distance;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_DISTANCE: prdata = {1'b0, target_distance};
      REG_SPEED:    prdata = {1'b0, top_speed};
      REG_ACCEL:    prdata = {1'b0, acceleration};
      default:      prdata = '0;
    endcase
  end

  // shared unit requests
  always_comb begin
    op_state  = 1'b1;
    u_ctrl.op = OP_DIV;
    u_opa     = '0;
    u_opb     = '0;
    case (state)
      S_DIST: begin
        u_opa = AW'(d_r) << FRAC_BITS;
        u_opb = v_r;
      end
      S_RAMP, S_RAMP2: begin
        u_opa = AW'(v_r) << FRAC_BITS;
        u_opb = a_r;
      end
      S_PROD: begin
        u_ctrl.op = OP_MUL;
        u_opa     = AW'(d_r);
        u_opb     = a_r;
      end
      S_ROOT: begin
        u_ctrl.op = OP_SQRT;
        u_opa     = work;
      end
      S_MUL: begin
        u_ctrl.op = OP_MUL;
        u_opa     = AW'(peak_speed);
        u_opb     = num[FIELD_BITS-1:0];
      end
      S_DIV: begin
        u_opa = work;
        u_opb = den[FIELD_BITS-1:0];
      end
      S_AVG: begin
        u_ctrl.op = OP_MUL;
        u_opa     = (AW'(previous_speed) + AW'(speed)) >> AVG_PRE;
        u_opb     = AVG_RECIP;
      end
      default: begin
        op_state = 1'b0;
      end
    endcase
    u_ctrl.start = op_state && !launched;
  end

  tvp_iter_unit #(
    .AW (AW)
  ) u_unit (
    .clk    (clk),
    .rst    (rst),
    .ctrl   (u_ctrl),
    .opa    (u_opa),
    .opb    (u_opb),
    .status (u_status),
    .result (u_result)
  );

  always_comb begin
    t_x      = XW'(t_r);
    ae_x     = XW'(accel_end_time);
    ce_x     = XW'(cruise_end_time);
    de_x     = XW'(decel_end_time);
    cend_val = triangle_flag ? t_ramp : t_dist;
    dsum     = {1'b0, cend_val} + {1'b0, t_ramp};
    pos_sum  = AW'(position_accumulator) + (u_result >> AVG_SHIFT);
  end

  assign req_ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state                <= S_IDLE;
      launched             <= 1'b0;
      rsp_valid            <= 1'b0;
      accel_end_time       <= '0;
      cruise_end_time      <= '0;
      decel_end_time       <= '0;
      peak_speed           <= '0;
      position_accumulator <= '0;
      previous_speed       <= '0;
      triangle_flag        <= 1'b0;
    end else begin
      if (rsp_valid && rsp_ready && (state != S_OUT)) begin
        rsp_valid <= 1'b0;
      end
      if (u_ctrl.start) begin
        launched <= 1'b1;
      end
      if (launched && u_status.done) begin
        launched <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (req_valid) begin
            t_r    <= sample_time;
            d_r    <= target_distance;
            v_r    <= (top_speed == '0) ? FIELD_BITS'(1) : top_speed;
            a_r    <= (acceleration == '0) ? FIELD_BITS'(1) : acceleration;
            state  <= func ? S_SEG : S_DIST;
          end
        end
        S_DIST: begin
          if (launched && u_status.done) begin
            t_dist <= sat_word(u_result);
            state  <= S_RAMP;
          end
        end
        S_RAMP: begin
          if (launched && u_status.done) begin
            t_ramp <= sat_word(u_result);
            state  <= S_CMP;
          end
        end
        S_CMP: begin
          triangle_flag <= (t_dist < t_ramp);
          state         <= (t_dist < t_ramp) ? S_PROD : S_ENDS;
        end
        S_PROD: begin
          if (launched && u_status.done) begin
            work  <= u_result;
            state <= S_ROOT;
          end
        end
        S_ROOT: begin
          if (launched && u_status.done) begin
            v_r   <= u_result[FIELD_BITS-1:0];
            state <= S_RAMP2;
          end
        end
        S_RAMP2: begin
          if (launched && u_status.done) begin
            t_ramp <= sat_word(u_result);
            state  <= S_ENDS;
          end
        end
        S_ENDS: begin
          peak_speed           <= sat_word(AW'(v_r));
          accel_end_time       <= t_ramp;
          cruise_end_time      <= cend_val;
          decel_end_time       <= dsum[WORD_BITS] ? '1 : dsum[WORD_BITS-1:0];
          position_accumulator <= '0;
          previous_speed       <= '0;
          speed                <= '0;
          seg_r                <= SEG_IDLE;
          state                <= S_OUT;
        end
        S_SEG: begin
          if (t_x == '0) begin
            speed <= '0;
            seg_r <= SEG_IDLE;
            state <= S_AVG;
          end else if (t_x <= ae_x) begin
            num   <= t_x;
            den   <= ae_x;
            seg_r <= SEG_ACCEL;
            state <= S_NORM;
          end else if (t_x <= ce_x) begin
            speed <= peak_speed;
            seg_r <= SEG_CRUISE;
            state <= S_AVG;
          end else if (t_x <= de_x) begin
            num   <= de_x - t_x;
            den   <= de_x - ce_x;
            seg_r <= SEG_DECEL;
            state <= S_NORM;
          end else begin
            speed <= '0;
            seg_r <= SEG_IDLE;
            state <= S_AVG;
          end
        end
        S_NORM: begin
          if (den[XW-1:FIELD_BITS] != '0) begin
            num <= num >> 1;
            den <= den >> 1;
          end else if (den == '0) begin
            speed <= '0;
            state <= S_AVG;
          end else begin
            state <= S_MUL;
          end
        end
        S_MUL: begin
          if (launched && u_status.done) begin
            work  <= u_result;
            state <= S_DIV;
          end
        end
        S_DIV: begin
          if (launched && u_status.done) begin
            speed <= u_result[WORD_BITS-1:0];
            state <= S_AVG;
          end
        end
        S_AVG: begin
          if (launched && u_status.done) begin
            state <= S_ACC;
          end
        end
        S_ACC: begin
          position_accumulator <= (pos_sum > POS_MAX) ? POS_MAX[WORD_BITS-1:0]
                                                      : pos_sum[WORD_BITS-1:0];
          previous_speed       <= speed;
          state                <= S_OUT;
        end
        S_OUT: begin
          if (!rsp_valid || rsp_ready) begin
            rsp_valid    <= 1'b1;
            velocity_ref <= FIELD_BITS'(speed);
            position_ref <= FIELD_BITS'(position_accumulator);
            segment      <= seg_r;
            triangular   <= triangle_flag;
            state        <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `include "trapezoidal_velocity_profile_core_assert.svh"

  `TVP_ASSERT_IMP(a_start_free, u_ctrl.start, !u_status.busy, "unit started while busy")
  `TVP_ASSERT_IMP(a_done_owned, u_status.done, launched, "unit result with no request")
  `TVP_ASSERT_IMP(a_pos_limit, 1'b1, AW'(position_accumulator) <= POS_MAX, "position past limit")

endmodule
